[design/positional_list_queue_engine_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the positional list queue engine.
// Every check samples on the rising edge of clk and is held off during rst.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_QUEUE_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_QUEUE_ENGINE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PLQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/plq_pkg.sv]
// ----------------------------------------------------------------------------
// plq_pkg
// Command codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package plq_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 6;

  localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE_LAST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_AT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_LAST   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE     = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd7;

  // Broadcast to every cell for one beat.
  typedef struct packed {
    logic ins;  // open a slot at the target index, cells above take the left word
    logic del;  // close the slot at the target index, cells from it take the right word
    logic rd;   // cell at the read index drives its word onto the gather tree
  } plq_ctl_t;

endpackage

[design/positional_list_queue_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_queue_engine: shifting-cell list with positional insert/delete
// Result path: gather stage register, then output register. Shifts finish on
// the command beat. in_stall holds new commands while the gather stage is full.
// Reset: rst (sync, high) empties the list and clears both valids; slot words
// are left as they are and are only read after being written.
// ----------------------------------------------------------------------------
`include "positional_list_queue_engine_assert.svh"

module positional_list_queue_engine
  import plq_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [CMD_W-1:0]                  command,
  input  logic [POS_W-1:0]                  position,
  input  logic [WORD_BITS-1:0]              value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic [WORD_BITS-1:0]              read_value,
  output logic [$clog2(CAPACITY + 1)-1:0]   entry_count,
  output logic                              is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

  // List occupancy
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Command decode
  logic             in_acc;
  logic             cmd_ok;
  plq_ctl_t         ctl_dec;
  plq_ctl_t         ctl;
  logic [IDX_W-1:0] at_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] pos_x;
  logic [IDX_W-1:0] cnt_x;
  logic             full;
  logic             empty;

  // Gather stage and output register
  logic             grp_valid;
  logic             grp_ok;
  logic [CNT_W-1:0] grp_count;
  logic             out_load;
  logic [WORD_BITS-1:0] gather_word;

  // Cell chain
  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_word;
  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_rd;

  assign in_stall = grp_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = grp_valid && (!out_valid || !out_stall);

  assign full  = (count == CNT_CAP);
  assign empty = (count == '0);
  assign pos_x = IDX_W'(position);
  assign cnt_x = IDX_W'(count);

  // Map each command onto the shift and read actions for the chain.
  always_comb begin
    cmd_ok     = 1'b0;
    ctl_dec    = '0;
    at_idx     = '0;
    rd_idx     = '0;
    count_next = count;
    unique case (command)
      CMD_APPEND: begin
        if (!full) begin
          ctl_dec.ins = 1'b1;
          at_idx      = cnt_x;
          cmd_ok      = 1'b1;
          count_next  = count + CNT_ONE;
        end
      end
      CMD_INSERT_AT: begin
        // Empty list rejects; a position at or past the tail appends.
        if (!empty && !full) begin
          ctl_dec.ins = 1'b1;
          at_idx      = (pos_x >= cnt_x) ? cnt_x : pos_x;
          cmd_ok      = 1'b1;
          count_next  = count + CNT_ONE;
        end
      end
      CMD_DELETE_LAST: begin
        // Drop the tail; no word moves.
        if (!empty) begin
          cmd_ok     = 1'b1;
          count_next = count - CNT_ONE;
        end
      end
      CMD_DELETE_AT: begin
        // Past the tail only stale slots shift, so the tail is what goes.
        if (!empty) begin
          ctl_dec.del = 1'b1;
          at_idx      = pos_x;
          cmd_ok      = 1'b1;
          count_next  = count - CNT_ONE;
        end
      end
      CMD_READ_AT: begin
        if (pos_x < cnt_x) begin
          ctl_dec.rd = 1'b1;
          rd_idx     = pos_x;
          cmd_ok     = 1'b1;
        end
      end
      CMD_READ_LAST: begin
        if (!empty) begin
          ctl_dec.rd = 1'b1;
          rd_idx     = cnt_x - IDX_W'(1);
          cmd_ok     = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        // Head is gathered before the chain shifts left on the same edge.
        if (!empty) begin
          ctl_dec.rd  = 1'b1;
          ctl_dec.del = 1'b1;
          cmd_ok      = 1'b1;
          count_next  = count - CNT_ONE;
        end
      end
      CMD_CLEAR: begin
        cmd_ok     = 1'b1;
        count_next = '0;
      end
    endcase
  end

  // Cells act only on the command beat.
  assign ctl = in_acc ? ctl_dec : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end

    plq_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at_idx     (at_idx),
      .rd_idx     (rd_idx),
      .value      (value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  plq_gather #(
    .WORD_BITS (WORD_BITS),
    .CAPACITY  (CAPACITY)
  ) u_gather (
    .clk        (clk),
    .load       (in_acc),
    .cell_words (cell_rd),
    .word       (gather_word)
  );

  // Occupancy advances on the command beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      count <= count_next;
    end
  end

  // Gather stage control: hold while the output register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        grp_valid <= 1'b1;
      end else if (out_load) begin
        grp_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      grp_ok    <= cmd_ok;
      grp_count <= count_next;
    end
  end

  // Output register: a finished beat waits here so the next command can enter.
  always_ff @(posedge clk) begin
    if (out_load) begin
      ok          <= grp_ok;
      read_value  <= gather_word;
      entry_count <= grp_count;
      is_empty    <= (grp_count == '0);
    end
  end

  `PLQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_CAP, "list count exceeds capacity")
  `PLQ_ASSERT_NEXT(a_count_hold, !in_acc, $stable(count), "count moved without a command")
  `PLQ_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0), "empty flag mismatch")
  `PLQ_ASSERT_NOW(a_fail_zero, out_valid && !ok, read_value == '0, "failed beat carries data")

endmodule

[design/plq_cell.sv]
// ----------------------------------------------------------------------------
// plq_cell
// One list slot: holds a word and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module plq_cell
  import plq_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 7,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  plq_ctl_t             ctl,
  input  logic [IDX_W-1:0]     at_idx,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic [WORD_BITS-1:0] value,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word,
  output logic [WORD_BITS-1:0] rd_word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX == at_idx) begin
        word <= value;
      end else if (MY_IDX > at_idx) begin
        word <= left_word;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= at_idx) begin
        word <= right_word;
      end
    end
  end

  assign rd_word = (ctl.rd && (MY_IDX == rd_idx)) ? word : '0;

endmodule

[design/plq_gather.sv]
// ----------------------------------------------------------------------------
// plq_gather
// Two-level OR tree that collects the selected cell word; first level registered.
// ----------------------------------------------------------------------------
module plq_gather #(
  parameter int WORD_BITS = 32,
  parameter int CAPACITY  = 64
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_words,
  output logic [WORD_BITS-1:0]               word
);

  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  logic [NGRP-1:0][WORD_BITS-1:0] grp;
  logic [NGRP-1:0][WORD_BITS-1:0] grp_next;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_words[g * GRP + k];
        end
      end
    end
  end

  // Capture group results on the command beat.
  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < NGRP; g++) begin
      word = word | grp[g];
    end
  end

endmodule
